[hdl/arpc_pkg.sv]
// Shared types and codes for the ARP neighbor cache.
package arpc_pkg;

  // Field widths of one transaction on each channel.
  localparam int unsigned IP_W    = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned ENTRY_W = IP_W + MAC_W;

  // Operation codes of an input transaction.
  localparam logic OP_LEARN  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Status codes of a result transaction.
  localparam logic [1:0] ST_UPDATED  = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_LOOKUP   = 2'd3;

  // One input transaction.
  typedef struct packed {
    logic             operation;
    logic [IP_W-1:0]  ip_address;
    logic [MAC_W-1:0] mac_address;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]         status;
    logic               hit;
    logic [MAC_W-1:0]   mac_found;
    logic [COUNT_W-1:0] entry_count;
  } out_item_t;

endpackage

[hdl/arpc_if.sv]
// Valid/ready channel interfaces for the ARP neighbor cache.
interface arpc_in_if;
  logic              valid;
  logic              ready;
  arpc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface arpc_out_if;
  logic               valid;
  logic               ready;
  arpc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/arpc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module arpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/arp_neighbor_cache_core.sv]
// Top level of the ARP neighbor cache: entry RAM, valid bits and scan sequencer.
//
//   Channel  Direction  Transaction content
//   -------  ---------  ------------------------------------------------------
//   in_ch    sink       operation, ip_address, mac_address
//   out_ch   source     status, hit, mac_found, entry_count
//
// Each transaction is accepted in S_IDLE, scanned in S_SCAN with one read per
// entry through the single read port of the entry RAM, compared as each read
// returns, and finished in S_FINISH. No new input is taken until its result is posted.
// Reset clears the valid bits and the entry count at once; no clearing pass.
// A finished result waits in the output register; while it is not taken, the
// next transaction's scan completes and then holds until the register frees.
module arp_neighbor_cache_core #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  arpc_in_if.sink           in_ch,
  arpc_out_if.source        out_ch
);
  import arpc_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                   state_r, state_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         scan_idx_r, scan_idx_nxt;
  logic                     issue_on_r, issue_on_nxt;
  logic                     cmp_valid_r, cmp_valid_nxt;
  logic [IDX_W-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic                     found_r, found_nxt;
  logic [IDX_W-1:0]         match_idx_r, match_idx_nxt;
  logic [MAC_W-1:0]         match_mac_r, match_mac_nxt;
  logic                     free_found_r, free_found_nxt;
  logic [IDX_W-1:0]         free_idx_r, free_idx_nxt;
  in_item_t                 item_r, item_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic                     ram_re;
  logic [ENTRY_W-1:0]       ram_rdata;
  logic [IP_W-1:0]          rd_ip;
  logic [MAC_W-1:0]         rd_mac;
  logic [EXT_W-1:0]         count_ext;

  // Entry RAM holds the address and MAC of every entry.
  arpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  assign rd_ip  = ram_rdata[ENTRY_W-1:MAC_W];
  assign rd_mac = ram_rdata[MAC_W-1:0];
  assign ram_re = (state_r == S_SCAN) && issue_on_r;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Next-state logic: scan issue, compare stage and finishing write.
  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    issue_on_nxt   = issue_on_r;
    cmp_valid_nxt  = 1'b0;
    cmp_idx_nxt    = scan_idx_r;
    found_nxt      = found_r;
    match_idx_nxt  = match_idx_r;
    match_mac_nxt  = match_mac_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    item_nxt       = item_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = match_idx_r;
    ram_wdata      = {item_r.ip_address, item_r.mac_address};
    count_ext      = '0;

    // The output register empties when the sink takes the result.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          item_nxt       = in_ch.data;
          scan_idx_nxt   = '0;
          issue_on_nxt   = 1'b1;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue one read per cycle until the last entry has been addressed.
        if (issue_on_r) begin
          cmp_valid_nxt = 1'b1;
          if (scan_idx_r == LAST_IDX) begin
            issue_on_nxt = 1'b0;
          end else begin
            scan_idx_nxt = scan_idx_r + IDX_W'(1);
          end
        end
        // Compare the entry read in the previous cycle.
        if (cmp_valid_r) begin
          if (valid_r[cmp_idx_r] && (rd_ip == item_r.ip_address) && !found_r) begin
            found_nxt     = 1'b1;
            match_idx_nxt = cmp_idx_r;
            match_mac_nxt = rd_mac;
          end
          if (!valid_r[cmp_idx_r] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = cmp_idx_r;
          end
          if (cmp_idx_r == LAST_IDX) begin
            state_nxt = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        // Write back a learned entry and post the result once the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_data_nxt.hit       = 1'b0;
          out_data_nxt.mac_found = '0;
          if (item_r.operation == OP_LOOKUP) begin
            out_data_nxt.status = ST_LOOKUP;
            if (found_r) begin
              out_data_nxt.hit       = 1'b1;
              out_data_nxt.mac_found = match_mac_r;
            end
          end else if (found_r) begin
            ram_we              = 1'b1;
            ram_waddr           = match_idx_r;
            out_data_nxt.status = ST_UPDATED;
          end else if (free_found_r) begin
            ram_we                  = 1'b1;
            ram_waddr               = free_idx_r;
            valid_nxt[free_idx_r]   = 1'b1;
            count_nxt               = count_r + CNT_W'(1);
            out_data_nxt.status     = ST_INSERTED;
          end else begin
            out_data_nxt.status = ST_FULL;
          end
          count_ext                = EXT_W'(count_nxt);
          out_data_nxt.entry_count = count_ext[COUNT_W-1:0];
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs; only control state is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      count_r      <= '0;
      issue_on_r   <= 1'b0;
      cmp_valid_r  <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      count_r      <= count_nxt;
      issue_on_r   <= issue_on_nxt;
      cmp_valid_r  <= cmp_valid_nxt;
      found_r      <= found_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    scan_idx_r  <= scan_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    match_idx_r <= match_idx_nxt;
    match_mac_r <= match_mac_nxt;
    free_idx_r  <= free_idx_nxt;
    item_r      <= item_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

[hdl/arpc_checker.sv]
// Port-level assertions for the ARP neighbor cache and their bind statement.
module arpc_checker #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   out_status,
  input logic                         out_hit,
  input logic [arpc_pkg::MAC_W-1:0]   out_mac_found,
  input logic [arpc_pkg::COUNT_W-1:0] out_entry_count
);
  import arpc_pkg::*;

  // A stalled result stays posted with the same content.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_hit) &&
       $stable(out_mac_found) && $stable(out_entry_count)))
    else $error("result changed while stalled");

  // Learn results and lookup misses carry no hit and a zero MAC.
  a_no_hit_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_status != ST_LOOKUP) || !out_hit)) |->
      (!out_hit && (out_mac_found == '0)))
    else $error("hit or MAC set on a result without a lookup hit");

  // The reported count never exceeds the table size; checked only for tables of up to 31 entries.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((TABLE_ENTRIES > 31) || (32'(out_entry_count) <= TABLE_ENTRIES)))
    else $error("entry count above table size");

  // One transaction at a time: the input closes right after an acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a scan is running");

endmodule

bind arp_neighbor_cache_core arpc_checker #(
  .TABLE_ENTRIES (TABLE_ENTRIES)
) u_arpc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.data.status),
  .out_hit         (out_ch.data.hit),
  .out_mac_found   (out_ch.data.mac_found),
  .out_entry_count (out_ch.data.entry_count)
);
